// ===== sv/gmpc_pkg.sv =====
// Shared types and constants for the grid minimum path cost checker.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package gmpc_pkg;

  localparam int CELL_W  = 11;  // signed cell value on the input channel
  localparam int VAL_W   = 10;  // magnitude of an open cell
  localparam int COST_W  = 18;  // path cost
  localparam int MC_W    = 17;  // reported minimum cost
  localparam int SIZE_W  = 7;   // grid_rows / grid_cols register width
  localparam int CFG_W   = 18;  // config write data width
  localparam int IDX_W   = 2;   // config register index width

  localparam logic [COST_W-1:0] COST_UNREACH = 18'h3FFFF;
  localparam logic [COST_W-1:0] COST_SAT     = 18'h3FFFE;
  localparam logic [MC_W-1:0]   MINCOST_MAX  = 17'h1FFFF;

  localparam logic [IDX_W-1:0] REG_GRID_ROWS    = 2'd0;
  localparam logic [IDX_W-1:0] REG_GRID_COLS    = 2'd1;
  localparam logic [IDX_W-1:0] REG_DANGER_LIMIT = 2'd2;

  // Per-cell classification made by the front end.
  typedef struct packed {
    logic blocked;    // sign bit set
    logic top;        // first row: no cell above
    logic left_edge;  // first column: no cell to the left
    logic last;       // bottom-right cell of the grid
  } ctrl_t;

endpackage

// ===== sv/gmpc_if.sv =====
// Stream channel interfaces: cell input and result output.
// Depends on gmpc_pkg.
`timescale 1ns / 1ps

interface gmpc_cell_if;
  logic                                valid;
  logic                                ready;
  logic signed [gmpc_pkg::CELL_W-1:0]  cell_value;

  modport source (output valid, output cell_value, input ready);
  modport sink   (input valid, input cell_value, output ready);
endinterface

interface gmpc_result_if;
  logic                          valid;
  logic                          ready;
  logic                          route_reachable;
  logic [gmpc_pkg::MC_W-1:0]     min_cost;
  logic                          route_ok;

  modport source (output valid, output route_reachable, output min_cost, output route_ok,
                  input ready);
  modport sink   (input valid, input route_reachable, input min_cost, input route_ok,
                  output ready);
endinterface

// ===== sv/gmpc_front.sv =====
// Front end: accepts cells, tracks raster position, classifies each cell.
// Depends on gmpc_pkg and gmpc_cell_if.
`timescale 1ns / 1ps

module gmpc_front #(
  parameter int CNT_W = 6
) (
  input  logic                       clk,
  input  logic                       rst,
  gmpc_cell_if.sink                  cell_in,
  input  logic                       restart,
  input  logic [CNT_W-1:0]           rows_last,
  input  logic [CNT_W-1:0]           cols_last,
  input  logic                       q_full,
  output logic                       push,
  output gmpc_pkg::ctrl_t            push_ctrl,
  output logic [gmpc_pkg::VAL_W-1:0] push_value,
  output logic [CNT_W-1:0]           push_col
);

  logic [CNT_W-1:0] row_cnt;
  logic [CNT_W-1:0] col_cnt;
  logic             end_of_row;
  logic             end_of_grid;

  assign cell_in.ready = !q_full;
  assign push          = cell_in.valid && !q_full;

  assign end_of_row  = (col_cnt == cols_last);
  assign end_of_grid = end_of_row && (row_cnt == rows_last);

  always_comb begin
    push_ctrl.blocked   = cell_in.cell_value[gmpc_pkg::CELL_W-1];
    push_ctrl.top       = (row_cnt == '0);
    push_ctrl.left_edge = (col_cnt == '0);
    push_ctrl.last      = end_of_grid;
  end

  assign push_value = cell_in.cell_value[gmpc_pkg::VAL_W-1:0];
  assign push_col   = col_cnt;

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      row_cnt <= '0;
      col_cnt <= '0;
    end else if (push) begin
      if (end_of_row) begin
        col_cnt <= '0;
        row_cnt <= end_of_grid ? '0 : row_cnt + 1'b1;
      end else begin
        col_cnt <= col_cnt + 1'b1;
      end
    end
  end

endmodule

// ===== sv/gmpc_queue.sv =====
// Two-entry FIFO between the front end and the cost engine.
// No package dependencies.
`timescale 1ns / 1ps

module gmpc_queue #(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  input  logic              pop,
  output logic [DATA_W-1:0] pop_data,
  output logic              full,
  output logic              empty
);

  logic [DATA_W-1:0] entry [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_data = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ===== sv/gmpc_back.sv =====
// Cost engine: row-above memory, left cost, per-cell cost update, result register.
// Depends on gmpc_pkg and gmpc_result_if.
`timescale 1ns / 1ps

module gmpc_back #(
  parameter int MAX_SIDE = 64,
  parameter int CNT_W    = 6
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_empty,
  input  gmpc_pkg::ctrl_t             q_ctrl,
  input  logic [gmpc_pkg::VAL_W-1:0]  q_value,
  input  logic [CNT_W-1:0]            q_col,
  output logic                        pop,
  input  logic [gmpc_pkg::COST_W-1:0] danger_limit,
  gmpc_result_if.source               result_out
);

  logic [gmpc_pkg::COST_W-1:0] row_above [MAX_SIDE];

  // execute stage
  logic                        exe_valid;
  gmpc_pkg::ctrl_t             exe_ctrl;
  logic [gmpc_pkg::VAL_W-1:0]  exe_value;
  logic [CNT_W-1:0]            exe_col;
  logic [gmpc_pkg::COST_W-1:0] above_rd;
  logic                        byp_hit;
  logic [gmpc_pkg::COST_W-1:0] byp_data;
  logic [gmpc_pkg::COST_W-1:0] left_cost;

  // result register
  logic                        res_valid;
  logic                        res_reach;
  logic [gmpc_pkg::MC_W-1:0]   res_min_cost;
  logic                        res_ok;

  logic                        exe_done;
  logic [gmpc_pkg::COST_W-1:0] above;
  logic [gmpc_pkg::COST_W-1:0] best;
  logic [gmpc_pkg::COST_W:0]   sum;
  logic [gmpc_pkg::COST_W-1:0] cost;

  // A last cell waits only if the result register is still occupied.
  assign exe_done = exe_valid && (!exe_ctrl.last || !res_valid || result_out.ready);
  assign pop      = !q_empty && (!exe_valid || exe_done);

  // The previous cell may write the same column in the cycle this one was read.
  assign above = byp_hit ? byp_data : above_rd;

  always_comb begin
    best = exe_ctrl.top ? gmpc_pkg::COST_UNREACH : above;
    if (!exe_ctrl.left_edge && (left_cost < best)) begin
      best = left_cost;
    end
    sum  = {1'b0, best} + {{(gmpc_pkg::COST_W + 1 - gmpc_pkg::VAL_W){1'b0}}, exe_value};
    cost = gmpc_pkg::COST_UNREACH;
    if (!exe_ctrl.blocked) begin
      if (exe_ctrl.top && exe_ctrl.left_edge) begin
        cost = {{(gmpc_pkg::COST_W - gmpc_pkg::VAL_W){1'b0}}, exe_value};
      end else if (best != gmpc_pkg::COST_UNREACH) begin
        cost = (sum > {1'b0, gmpc_pkg::COST_SAT}) ? gmpc_pkg::COST_SAT
                                                  : sum[gmpc_pkg::COST_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exe_done) begin
      row_above[exe_col] <= cost;
    end
    if (pop) begin
      above_rd <= row_above[q_col];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      exe_ctrl  <= q_ctrl;
      exe_value <= q_value;
      exe_col   <= q_col;
      byp_hit   <= exe_done && (exe_col == q_col);
      byp_data  <= cost;
    end
    if (exe_done) begin
      left_cost <= cost;
    end
    if (exe_done && exe_ctrl.last) begin
      res_reach    <= (cost != gmpc_pkg::COST_UNREACH);
      res_min_cost <= (cost == gmpc_pkg::COST_UNREACH) ? '0 :
                      (cost > {1'b0, gmpc_pkg::MINCOST_MAX}) ? gmpc_pkg::MINCOST_MAX :
                      cost[gmpc_pkg::MC_W-1:0];
      res_ok       <= (cost != gmpc_pkg::COST_UNREACH) && (cost <= danger_limit);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      exe_valid <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (pop) begin
        exe_valid <= 1'b1;
      end else if (exe_done) begin
        exe_valid <= 1'b0;
      end
      if (exe_done && exe_ctrl.last) begin
        res_valid <= 1'b1;
      end else if (result_out.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  assign result_out.valid           = res_valid;
  assign result_out.route_reachable = res_reach;
  assign result_out.min_cost        = res_min_cost;
  assign result_out.route_ok        = res_ok;

endmodule

// ===== sv/grid_min_path_cost_check.sv =====
// Top level of the grid minimum path cost checker: config registers, front end,
// queue and cost engine. Depends on gmpc_pkg, gmpc_if, gmpc_front, gmpc_queue, gmpc_back.
`timescale 1ns / 1ps

// Usage
//   cell_in    : one grid cell per transfer, raster order (row by row, left to
//                right). A negative cell_value marks a blocked cell.
//   result_out : one transfer per grid, after its bottom-right cell, giving
//                route_reachable, min_cost (0 if unreachable, clipped to
//                131071) and route_ok (reachable and cost <= danger_limit).
//   cfg_*      : write port. Index 0 grid_rows, 1 grid_cols, 2 danger_limit.
//                Sizes (cfg_wdata[6:0]) of 0 count as 1, above MAX_SIDE as MAX_SIDE.
//                Writing a size restarts the grid at the top-left cell.
//                Write only while no grid is in flight.
// Throughput: one cell per cycle while nothing stalls; the cost engine does one add and
//   one compare per cell against a one-row cost memory.
// Stall: a 2-entry queue sits between the front end and the cost engine; if
//   result_out is held, the last cell waits in the engine, the queue fills and
//   cell_in.ready drops. Cells of the next grid keep flowing until then.
// Reset: sizes 64 x 64, danger_limit 0, position at the top-left cell.
//   The row memory is not cleared; the first row never uses what it reads from it.

module grid_min_path_cost_check #(
  parameter int MAX_SIDE = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  gmpc_cell_if.sink                  cell_in,
  gmpc_result_if.source              result_out,
  input  logic                       cfg_we,
  input  logic [gmpc_pkg::IDX_W-1:0] cfg_index,
  input  logic [gmpc_pkg::CFG_W-1:0] cfg_wdata
);

  localparam int CNT_W  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int ITEM_W = $bits(gmpc_pkg::ctrl_t) + gmpc_pkg::VAL_W + CNT_W;

  // Effective size minus one: the last row/column index.
  function automatic logic [CNT_W-1:0] side_last(input logic [gmpc_pkg::SIZE_W-1:0] v);
    logic [31:0] wide;
    wide = {{(32 - gmpc_pkg::SIZE_W){1'b0}}, v};
    if (wide == 32'd0) begin
      return '0;
    end else if (wide > MAX_SIDE) begin
      return CNT_W'(MAX_SIDE - 1);
    end else begin
      return CNT_W'(wide - 32'd1);
    end
  endfunction

  // Config registers (sizes held already clamped)
  logic [CNT_W-1:0]            rows_last;
  logic [CNT_W-1:0]            cols_last;
  logic [gmpc_pkg::COST_W-1:0] danger_limit;
  logic                        restart;

  assign restart = cfg_we && ((cfg_index == gmpc_pkg::REG_GRID_ROWS) ||
                              (cfg_index == gmpc_pkg::REG_GRID_COLS));

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_last    <= side_last(7'd64);
      cols_last    <= side_last(7'd64);
      danger_limit <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        gmpc_pkg::REG_GRID_ROWS:    rows_last    <= side_last(cfg_wdata[gmpc_pkg::SIZE_W-1:0]);
        gmpc_pkg::REG_GRID_COLS:    cols_last    <= side_last(cfg_wdata[gmpc_pkg::SIZE_W-1:0]);
        gmpc_pkg::REG_DANGER_LIMIT: danger_limit <= cfg_wdata[gmpc_pkg::COST_W-1:0];
        default: ;
      endcase
    end
  end

  // Front end -> queue
  logic                       push;
  gmpc_pkg::ctrl_t            push_ctrl;
  logic [gmpc_pkg::VAL_W-1:0] push_value;
  logic [CNT_W-1:0]           push_col;
  logic                       q_full;
  logic                       q_empty;
  logic                       pop;
  logic [ITEM_W-1:0]          q_data;

  // Queue -> cost engine
  gmpc_pkg::ctrl_t            q_ctrl;
  logic [gmpc_pkg::VAL_W-1:0] q_value;
  logic [CNT_W-1:0]           q_col;

  gmpc_front #(
    .CNT_W (CNT_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cell_in    (cell_in),
    .restart    (restart),
    .rows_last  (rows_last),
    .cols_last  (cols_last),
    .q_full     (q_full),
    .push       (push),
    .push_ctrl  (push_ctrl),
    .push_value (push_value),
    .push_col   (push_col)
  );

  gmpc_queue #(
    .DATA_W (ITEM_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_ctrl, push_value, push_col}),
    .pop       (pop),
    .pop_data  (q_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  assign {q_ctrl, q_value, q_col} = q_data;

  gmpc_back #(
    .MAX_SIDE (MAX_SIDE),
    .CNT_W    (CNT_W)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_ctrl       (q_ctrl),
    .q_value      (q_value),
    .q_col        (q_col),
    .pop          (pop),
    .danger_limit (danger_limit),
    .result_out   (result_out)
  );

endmodule
